// ===== rtl/bzc_pkg.sv =====
`default_nettype none

package bzc_pkg;

  localparam int unsigned CoordW    = 16;
  localparam int unsigned TW        = 16;
  localparam int unsigned UW        = TW + 1;
  localparam int unsigned T3W       = TW + 2;
  localparam int unsigned UuW       = 2 * TW + 1;
  localparam int unsigned UtW       = 2 * TW - 1;
  localparam int unsigned TtW       = 2 * TW;
  localparam int unsigned FracShift = 3 * TW;
  localparam int unsigned WgtW      = FracShift + 1;
  localparam int unsigned LoW       = 25;
  localparam int unsigned HiW       = WgtW - LoW;
  localparam int unsigned LoPW      = LoW + 1 + CoordW;
  localparam int unsigned HiPW      = HiW + 1 + CoordW;
  localparam int unsigned SumW      = WgtW + CoordW + 2;
  localparam int unsigned NumWgt    = 4;
  localparam int unsigned NumStages = 6;

  localparam int unsigned StgPoly  = 0;
  localparam int unsigned StgWgt   = 1;
  localparam int unsigned StgPart  = 2;
  localparam int unsigned StgProd  = 3;
  localparam int unsigned StgPair  = 4;
  localparam int unsigned StgRound = 5;

  typedef logic [NumStages-1:0]             stage_en_t;
  typedef logic [WgtW-1:0]                  wgt_t;
  typedef logic [NumWgt-1:0][WgtW-1:0]      wgt_vec_t;
  typedef logic signed [CoordW-1:0]         coord_t;
  typedef logic [NumWgt-1:0][CoordW-1:0]    coord_vec_t;

endpackage

`default_nettype wire

// ===== rtl/bzc_weights.sv =====
`default_nettype none

module bzc_weights (
  input  logic                      clk_i,
  input  bzc_pkg::stage_en_t        en_i,
  input  logic                      cubic_mode_i,
  input  logic [bzc_pkg::TW-1:0]    curve_t_i,
  output bzc_pkg::wgt_vec_t         w_o
);
  import bzc_pkg::*;

  logic            cubic_q;
  logic [UW-1:0]   u_d, u_q;
  logic [TW-1:0]   t_q;
  logic [T3W-1:0]  t3_d, t3_q;
  logic [UuW-1:0]  uu_d, uu_q;
  logic [UtW-1:0]  ut_d, ut_q;
  logic [TtW-1:0]  tt_d, tt_q;
  wgt_vec_t        w_d, w_q;

  always_comb begin
    u_d  = (UW'(1) << TW) - UW'(curve_t_i);
    t3_d = T3W'(curve_t_i) + (T3W'(curve_t_i) << 1);
    uu_d = UuW'(u_d) * UuW'(u_d);
    ut_d = UtW'(UuW'(u_d) * UuW'(curve_t_i));
    tt_d = TtW'(curve_t_i) * TtW'(curve_t_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[StgPoly]) begin
      cubic_q <= cubic_mode_i;
      u_q     <= u_d;
      t_q     <= curve_t_i;
      t3_q    <= t3_d;
      uu_q    <= uu_d;
      ut_q    <= ut_d;
      tt_q    <= tt_d;
    end
  end

  always_comb begin
    if (cubic_q) begin
      w_d[0] = WgtW'(uu_q) * WgtW'(u_q);
      w_d[1] = WgtW'(uu_q) * WgtW'(t3_q);
      w_d[2] = WgtW'(ut_q) * WgtW'(t3_q);
      w_d[3] = WgtW'(tt_q) * WgtW'(t_q);
    end else begin
      w_d[0] = WgtW'(uu_q) << TW;
      w_d[1] = WgtW'(ut_q) << (TW + 1);
      w_d[2] = WgtW'(tt_q) << TW;
      w_d[3] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[StgWgt]) begin
      w_q <= w_d;
    end
  end

  assign w_o = w_q;

endmodule

`default_nettype wire

// ===== rtl/bzc_axis.sv =====
`default_nettype none

module bzc_axis (
  input  logic                  clk_i,
  input  bzc_pkg::stage_en_t    en_i,
  input  bzc_pkg::coord_vec_t   coord_i,
  input  bzc_pkg::wgt_vec_t     w_i,
  output bzc_pkg::coord_t       point_o
);
  import bzc_pkg::*;

  localparam logic signed [SumW-1:0] Half = SumW'(1) << (FracShift - 1);

  coord_vec_t                c1_q, c2_q;
  logic signed [LoPW-1:0]    lo_q   [NumWgt];
  logic signed [HiPW-1:0]    hi_q   [NumWgt];
  logic signed [SumW-1:0]    prod_q [NumWgt];
  logic signed [SumW-1:0]    s01_q, s23_q;
  logic signed [SumW-1:0]    tot_d;
  coord_t                    point_q;

  always_ff @(posedge clk_i) begin
    if (en_i[StgPoly]) begin
      c1_q <= coord_i;
    end
    if (en_i[StgWgt]) begin
      c2_q <= c1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[StgPart]) begin
      for (int k = 0; k < NumWgt; k++) begin
        lo_q[k] <= $signed({1'b0, w_i[k][LoW-1:0]}) * $signed(c2_q[k]);
        hi_q[k] <= $signed({1'b0, w_i[k][WgtW-1:LoW]}) * $signed(c2_q[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[StgProd]) begin
      for (int k = 0; k < NumWgt; k++) begin
        prod_q[k] <= (SumW'(hi_q[k]) <<< LoW) + SumW'(lo_q[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[StgPair]) begin
      s01_q <= prod_q[0] + prod_q[1];
      s23_q <= prod_q[2] + prod_q[3];
    end
  end

  assign tot_d = s01_q + s23_q + Half;

  always_ff @(posedge clk_i) begin
    if (en_i[StgRound]) begin
      point_q <= tot_d[FracShift+CoordW-1:FracShift];
    end
  end

  assign point_o = point_q;

endmodule

`default_nettype wire

// ===== rtl/bezier_curve_point_eval.sv =====
// Bezier curve point evaluator.
// Input channel (in_valid_i / in_ready_o) carries one transaction per point:
// four control points in signed Q12.4, curve_t_i as unsigned Q0.16 and
// cubic_mode_i (1: cubic over p0..p3, 0: quadratic over p0..p2, p3 ignored).
// Output channel (point_valid_o / point_ready_i) returns point_x_o and
// point_y_o in signed Q12.4, rounded to nearest with ties toward plus infinity.
// From acceptance to point_valid_o, two stages build the Bernstein weights with
// 17x17 and 33x18 multipliers, one forms split partial products of weight
// times coordinate, then product merge, pair sum, and the final sum with
// rounding. Throughput is one transaction per cycle while points are taken.
// Each stage carries a valid bit and advances when its successor is empty or
// advancing, so a stalled receiver holds the output and the pipeline fills up;
// in_ready_o drops only once all six stages hold transactions.
// Reset clears all valid bits; no transaction is in flight afterwards.
`default_nettype none

module bezier_curve_point_eval (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           cubic_mode_i,
  input  bzc_pkg::coord_t                p0_x_i,
  input  bzc_pkg::coord_t                p0_y_i,
  input  bzc_pkg::coord_t                p1_x_i,
  input  bzc_pkg::coord_t                p1_y_i,
  input  bzc_pkg::coord_t                p2_x_i,
  input  bzc_pkg::coord_t                p2_y_i,
  input  bzc_pkg::coord_t                p3_x_i,
  input  bzc_pkg::coord_t                p3_y_i,
  input  logic [bzc_pkg::TW-1:0]         curve_t_i,
  output logic                           point_valid_o,
  input  logic                           point_ready_i,
  output bzc_pkg::coord_t                point_x_o,
  output bzc_pkg::coord_t                point_y_o
);
  import bzc_pkg::*;

  logic [NumStages-1:0] v_d, v_q;
  stage_en_t            en;
  wgt_vec_t             w;
  coord_vec_t           cx, cy;
  logic                 in_fire, out_fire;

  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || point_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_comb begin
    v_d = v_q;
    if (en[0]) begin
      v_d[0] = in_valid_i;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (en[k]) begin
        v_d[k] = v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_ready_o    = en[0];
  assign point_valid_o = v_q[NumStages-1];
  assign in_fire       = in_valid_i && in_ready_o;
  assign out_fire      = point_valid_o && point_ready_i;

  assign cx = {p3_x_i, p2_x_i, p1_x_i, p0_x_i};
  assign cy = {p3_y_i, p2_y_i, p1_y_i, p0_y_i};

  bzc_weights u_weights (
    .clk_i        (clk_i),
    .en_i         (en),
    .cubic_mode_i (cubic_mode_i),
    .curve_t_i    (curve_t_i),
    .w_o          (w)
  );

  bzc_axis u_axis_x (
    .clk_i   (clk_i),
    .en_i    (en),
    .coord_i (cx),
    .w_i     (w),
    .point_o (point_x_o)
  );

  bzc_axis u_axis_y (
    .clk_i   (clk_i),
    .en_i    (en),
    .coord_i (cy),
    .w_i     (w),
    .point_o (point_y_o)
  );

  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> v_q[0])
    else $error("accepted transaction did not enter the first stage");

  a_ready_with_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(&v_q) |-> in_ready_o)
    else $error("input stalled while a stage is empty");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&v_q) && !point_ready_i) |-> !in_ready_o)
    else $error("input accepted into a full, stalled pipeline");

  a_count_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> ($countones(v_q) ==
      $countones($past(v_q)) + int'($past(in_fire)) - int'($past(out_fire))))
    else $error("transaction lost or duplicated in the pipeline");

endmodule

`default_nettype wire

// ===== tb/sv/bezier_point_checker.sv =====
`timescale 1ns / 100ps

module bezier_point_checker (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic                    cubic_mode_i,
  input  bzc_pkg::coord_t         p0_x_i,
  input  bzc_pkg::coord_t         p0_y_i,
  input  bzc_pkg::coord_t         p1_x_i,
  input  bzc_pkg::coord_t         p1_y_i,
  input  bzc_pkg::coord_t         p2_x_i,
  input  bzc_pkg::coord_t         p2_y_i,
  input  bzc_pkg::coord_t         p3_x_i,
  input  bzc_pkg::coord_t         p3_y_i,
  input  logic [bzc_pkg::TW-1:0]  curve_t_i,
  input  logic                    point_valid_i,
  input  logic                    point_ready_i,
  input  bzc_pkg::coord_t         point_x_i,
  input  bzc_pkg::coord_t         point_y_i,
  output int                      mismatch_cnt_o,
  output int                      points_pending_o
);
  import bzc_pkg::*;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } curve_point_t;

  curve_point_t point_q[$];
  int           mismatches = 0;

  function automatic coord_t bernstein_axis(input logic cubic, input coord_t a0,
                                            input coord_t a1, input coord_t a2,
                                            input coord_t a3, input logic [TW-1:0] t);
    logic signed [69:0] tv;
    logic signed [69:0] uv;
    logic signed [69:0] w0;
    logic signed [69:0] w1;
    logic signed [69:0] w2;
    logic signed [69:0] w3;
    logic signed [69:0] acc;
    tv = {54'd0, t};
    uv = 70'sd65536 - tv;
    if (cubic) begin
      w0 = uv * uv * uv;
      w1 = 70'sd3 * uv * uv * tv;
      w2 = 70'sd3 * uv * tv * tv;
      w3 = tv * tv * tv;
    end else begin
      w0 = (uv * uv) <<< 16;
      w1 = (70'sd2 * uv * tv) <<< 16;
      w2 = (tv * tv) <<< 16;
      w3 = '0;
    end
    acc = w0 * a0 + w1 * a1 + w2 * a2 + w3 * a3;
    acc = acc + (70'sd1 <<< 47);
    acc = acc >>> 48;
    return coord_t'(acc[CoordW-1:0]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    curve_point_t want;
    if (!rst_ni) begin
      point_q.delete();
      points_pending_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        want.x = bernstein_axis(cubic_mode_i, p0_x_i, p1_x_i, p2_x_i, p3_x_i, curve_t_i);
        want.y = bernstein_axis(cubic_mode_i, p0_y_i, p1_y_i, p2_y_i, p3_y_i, curve_t_i);
        point_q = {point_q, want};
      end
      if (point_valid_i && point_ready_i) begin
        if (point_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected point x=%0d y=%0d", $time, point_x_i, point_y_i);
        end else begin
          want = point_q.pop_front();
          if (want.x !== point_x_i || want.y !== point_y_i) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: point mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                       $time, want.x, want.y, point_x_i, point_y_i);
          end
        end
      end
      points_pending_o <= point_q.size();
    end
  end

  assign mismatch_cnt_o = mismatches;

endmodule

// ===== tb/sv/bezier_curve_point_eval_test.sv =====
`timescale 1ns / 100ps

module bezier_curve_point_eval_test;
  import bzc_pkg::*;

  typedef struct packed {
    logic          cubic;
    coord_vec_t    xs;
    coord_vec_t    ys;
    logic [TW-1:0] t;
  } curve_req_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic          cubic_mode = 1'b0;
  coord_t        p0_x = '0;
  coord_t        p0_y = '0;
  coord_t        p1_x = '0;
  coord_t        p1_y = '0;
  coord_t        p2_x = '0;
  coord_t        p2_y = '0;
  coord_t        p3_x = '0;
  coord_t        p3_y = '0;
  logic [TW-1:0] curve_t = '0;
  logic          point_valid;
  logic          point_ready = 1'b0;
  coord_t        point_x;
  coord_t        point_y;
  int            mismatch_cnt;
  int            points_pending;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;

  always #2 clk_i = ~clk_i;

  bezier_curve_point_eval u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .cubic_mode_i (cubic_mode),
    .p0_x_i       (p0_x),
    .p0_y_i       (p0_y),
    .p1_x_i       (p1_x),
    .p1_y_i       (p1_y),
    .p2_x_i       (p2_x),
    .p2_y_i       (p2_y),
    .p3_x_i       (p3_x),
    .p3_y_i       (p3_y),
    .curve_t_i    (curve_t),
    .point_valid_o(point_valid),
    .point_ready_i(point_ready),
    .point_x_o    (point_x),
    .point_y_o    (point_y)
  );

  bezier_point_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .cubic_mode_i    (cubic_mode),
    .p0_x_i          (p0_x),
    .p0_y_i          (p0_y),
    .p1_x_i          (p1_x),
    .p1_y_i          (p1_y),
    .p2_x_i          (p2_x),
    .p2_y_i          (p2_y),
    .p3_x_i          (p3_x),
    .p3_y_i          (p3_y),
    .curve_t_i       (curve_t),
    .point_valid_i   (point_valid),
    .point_ready_i   (point_ready),
    .point_x_i       (point_x),
    .point_y_i       (point_y),
    .mismatch_cnt_o  (mismatch_cnt),
    .points_pending_o(points_pending)
  );

  always @(posedge clk_i) begin
    point_ready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic curve_req_t make_req(input logic cubic, input int x0, input int x1,
                                          input int x2, input int x3, input int y0,
                                          input int y1, input int y2, input int y3,
                                          input int t);
    curve_req_t r;
    r.cubic = cubic;
    r.xs = {coord_t'(x3), coord_t'(x2), coord_t'(x1), coord_t'(x0)};
    r.ys = {coord_t'(y3), coord_t'(y2), coord_t'(y1), coord_t'(y0)};
    r.t  = t[TW-1:0];
    return r;
  endfunction

  function automatic coord_t rand_coord(input coord_t anchor);
    coord_t c;
    case ($urandom_range(3))
      0: c = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      1: c = anchor + coord_t'($urandom_range(512) - 256);
      default: c = coord_t'($urandom);
    endcase
    return c;
  endfunction

  function automatic curve_req_t rand_req();
    curve_req_t r;
    coord_t     anchor;
    anchor  = coord_t'($urandom);
    r.cubic = $urandom_range(3) != 0;
    for (int i = 0; i < NumWgt; i++) begin
      r.xs[i] = rand_coord(anchor);
      r.ys[i] = rand_coord(anchor);
    end
    case ($urandom_range(7))
      0: r.t = '0;
      1: r.t = '1;
      2: r.t = 16'h8000;
      default: r.t = TW'($urandom);
    endcase
    return r;
  endfunction

  task automatic send_req(input curve_req_t r);
    logic ready_seen;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    cubic_mode <= r.cubic;
    p0_x       <= r.xs[0];
    p1_x       <= r.xs[1];
    p2_x       <= r.xs[2];
    p3_x       <= r.xs[3];
    p0_y       <= r.ys[0];
    p1_y       <= r.ys[1];
    p2_y       <= r.ys[2];
    p3_y       <= r.ys[3];
    curve_t    <= r.t;
    do begin
      @(negedge clk_i);
      ready_seen = in_ready;
      @(posedge clk_i);
    end while (!ready_seen);
  endtask

  initial begin
    #2_000_000;
    $display("** bezier_curve_point_eval: FAILED **");
    $finish;
  end

  initial begin
    int idle_plan[4];
    int stall_plan[4];
    idle_plan  = '{0, 66, 0, 12};
    stall_plan = '{0, 0, 66, 12};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_req(make_req(1, 100, -200, 300, -400, 5, 6, 7, 8, 0));
    send_req(make_req(1, 100, -200, 300, -400, 5, 6, 7, 8, 65535));
    send_req(make_req(0, 100, -200, 300, 999, 5, 6, 7, -999, 65535));
    send_req(make_req(1, -32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767, 12345));
    send_req(make_req(0, -32768, -32768, -32768, 32767, 32767, 32767, 32767, -32768, 54321));
    send_req(make_req(1, -32768, 32767, -32768, 32767, 32767, -32768, 32767, -32768, 32768));
    send_req(make_req(0, -32768, 32767, -32768, 0, 32767, -32768, 32767, 0, 32768));
    send_req(make_req(1, -32768, -32768, 32767, 32767, 32767, 32767, -32768, -32768, 1));
    send_req(make_req(1, 32767, 32767, 32767, -32768, -32768, -32768, -32768, 32767, 65535));
    // round half up: +0.5 LSB goes to 1, -0.5 LSB goes to 0
    send_req(make_req(0, 1, 0, 1, 0, -1, 0, -1, 0, 32768));
    send_req(make_req(1, 1, 1, 0, 0, 0, 0, -1, -1, 32768));
    send_req(make_req(1, 0, 0, -1, -1, 1, 1, 0, 0, 32768));
    send_req(make_req(0, -1, 0, -1, 0, 1, 0, 1, 0, 32768));
    send_req(make_req(0, 0, 0, 0, -32768, 0, 0, 0, 32767, 40000));
    send_req(make_req(0, 0, 0, 0, 32767, 0, 0, 0, -32768, 40000));
    send_req(make_req(1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_req(make_req(1, -1, -1, -1, -1, -1, -1, -1, -1, 65535));

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_plan[ph];
      recv_stall_pct = stall_plan[ph];
      repeat (135) send_req(rand_req());
    end
    in_valid <= 1'b0;
    recv_stall_pct = 0;

    while (points_pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("** bezier_curve_point_eval: PASSED **");
    end else begin
      $display("** bezier_curve_point_eval: FAILED **");
    end
    $finish;
  end

endmodule

// ===== bezier_curve_point_eval.f =====
rtl/bzc_pkg.sv
rtl/bzc_weights.sv
rtl/bzc_axis.sv
rtl/bezier_curve_point_eval.sv
tb/sv/bezier_point_checker.sv
tb/sv/bezier_curve_point_eval_test.sv
